### hdl/masked_byte_signature_scan_assert.svh
// Assertion macros used by the checker of this block.
`ifndef MASKED_BYTE_SIGNATURE_SCAN_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mbss_pkg.sv
`default_nettype none

package mbss_pkg;

  // Pattern and window sizes.
  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = MAX_PATTERN + 1;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WILDCARD_MASK  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STRING_MODE    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_BASE    = 3'd5;

  typedef logic [7:0] octet_t;

  // Byte history, entry 0 is the newest byte.
  typedef octet_t [WIN_DEPTH-1:0] window_t;

  // Pattern bytes, entry 0 is pattern byte 0.
  typedef octet_t [MAX_PATTERN-1:0] pattern_t;

  // Input word.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        match_found;
    logic [31:0] match_address;
  } out_word_t;

  // Configuration register contents.
  typedef struct packed {
    logic [63:0]      pattern_low;
    logic [63:0]      pattern_high;
    logic [15:0]      wildcard_mask;
    logic [LEN_W-1:0] pattern_length;
    logic             string_mode;
    logic [31:0]      search_base;
  } cfg_t;

  // Contents of the input stage handed to the compare stage.
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [31:0] offset;
    window_t     window;
  } stage_t;

endpackage

`default_nettype wire

### hdl/masked_byte_signature_scan.sv
// Each accepted byte enters the input stage register; its result word is registered in
// the result register and then offered until taken.
// Throughput: one byte per cycle while results are taken. A byte that makes no result
// passes a waiting result; a byte that makes one holds the input until it is taken.
// Reset (rst_n low, synchronous): clears the pipeline, starts a new region and
// loads the registers with their reset values; no clearing pass is needed.
`default_nettype none

module masked_byte_signature_scan (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire mbss_pkg::in_word_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output mbss_pkg::out_word_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbss_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbss_pkg::DATA_W-1:0] pwdata,
  output logic      [mbss_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  mbss_pkg::cfg_t   cfg;
  mbss_pkg::stage_t stg;
  logic             adv;

  // Register file.
  mbss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register and byte history.
  mbss_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .stg      (stg)
  );

  // Pattern compare and result register.
  mbss_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg       (stg),
    .cfg       (cfg),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hdl/mbss_cfg.sv
`default_nettype none

module mbss_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mbss_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbss_pkg::DATA_W-1:0] pwdata,
  output logic      [mbss_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output mbss_pkg::cfg_t                  cfg
);

  mbss_pkg::cfg_t                    cfg_r;
  logic [mbss_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[mbss_pkg::ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.wildcard_mask  <= '0;
      cfg_r.pattern_length <= mbss_pkg::LEN_W'(1);
      cfg_r.string_mode    <= 1'b0;
      cfg_r.search_base    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mbss_pkg::REG_PATTERN_LOW:    cfg_r.pattern_low    <= pwdata;
        mbss_pkg::REG_PATTERN_HIGH:   cfg_r.pattern_high   <= pwdata;
        mbss_pkg::REG_WILDCARD_MASK:  cfg_r.wildcard_mask  <= pwdata[15:0];
        mbss_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= pwdata[mbss_pkg::LEN_W-1:0];
        mbss_pkg::REG_STRING_MODE:    cfg_r.string_mode    <= pwdata[0];
        mbss_pkg::REG_SEARCH_BASE:    cfg_r.search_base    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (reg_idx)
      mbss_pkg::REG_PATTERN_LOW:    prdata = cfg_r.pattern_low;
      mbss_pkg::REG_PATTERN_HIGH:   prdata = cfg_r.pattern_high;
      mbss_pkg::REG_WILDCARD_MASK:  prdata = {48'd0, cfg_r.wildcard_mask};
      mbss_pkg::REG_PATTERN_LENGTH: prdata = {59'd0, cfg_r.pattern_length};
      mbss_pkg::REG_STRING_MODE:    prdata = {63'd0, cfg_r.string_mode};
      mbss_pkg::REG_SEARCH_BASE:    prdata = {32'd0, cfg_r.search_base};
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/mbss_window.sv
`default_nettype none

module mbss_window (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mbss_pkg::in_word_t in_data,
  input  wire logic               adv,
  output mbss_pkg::stage_t        stg
);

  mbss_pkg::stage_t  stg_r;
  mbss_pkg::stage_t  stg_nxt;
  logic              seg_start_r;
  logic              seg_start_nxt;
  logic              acc;
  mbss_pkg::window_t base_win;

  assign in_ready = !stg_r.valid || adv;
  assign acc      = in_valid && in_ready;
  assign stg      = stg_r;

  // Shift the new byte in; the first byte of a region starts from a clear window.
  always_comb begin
    stg_nxt       = stg_r;
    seg_start_nxt = seg_start_r;
    base_win      = seg_start_r ? '0 : stg_r.window;
    if (acc) begin
      stg_nxt.valid  = 1'b1;
      stg_nxt.last   = in_data.last_byte;
      stg_nxt.offset = seg_start_r ? 32'd0 : stg_r.offset + 32'd1;
      stg_nxt.window = {base_win[mbss_pkg::WIN_DEPTH-2:0], in_data.data_byte};
      seg_start_nxt  = in_data.last_byte;
    end else if (adv) begin
      stg_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
      seg_start_r <= 1'b1;
    end else begin
      stg_r       <= stg_nxt;
      seg_start_r <= seg_start_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/mbss_match.sv
`default_nettype none

module mbss_match (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mbss_pkg::stage_t    stg,
  input  wire mbss_pkg::cfg_t      cfg,
  output logic                     adv,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mbss_pkg::out_word_t      out_data
);

  mbss_pkg::pattern_t           pat;
  logic [mbss_pkg::LEN_W-1:0]   len;
  logic [mbss_pkg::IDX_W-1:0]   len_m1;
  logic [mbss_pkg::IDX_W-1:0]   pidx;
  logic [mbss_pkg::MAX_PATTERN-1:0] pos_ok;
  logic [7:0]                   prev_byte;
  logic [31:0]                  start;
  logic                         off_ok;
  logic                         str_fail;
  logic                         hit;
  logic                         emit;
  logic                         slot_free;
  logic                         done_r;
  logic                         out_valid_r;
  mbss_pkg::out_word_t          out_data_r;

  assign pat = {cfg.pattern_high, cfg.pattern_low};

  // Clamp the length to 1..MAX_PATTERN.
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = mbss_pkg::LEN_W'(1);
    end else if (cfg.pattern_length > mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN)) begin
      len = mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
  end

  assign len_m1 = mbss_pkg::IDX_W'(len - mbss_pkg::LEN_W'(1));

  // Window entry k holds the byte for pattern position len-1-k.
  always_comb begin
    pidx = '0;
    for (int k = 0; k < mbss_pkg::MAX_PATTERN; k++) begin
      pidx      = len_m1 - mbss_pkg::IDX_W'(k);
      pos_ok[k] = (mbss_pkg::LEN_W'(k) >= len) || cfg.wildcard_mask[pidx] ||
                  (pat[pidx] == stg.window[k]);
    end
  end

  // Start of the candidate match and the byte in front of it.
  assign prev_byte = stg.window[len];
  assign off_ok    = stg.offset >= {28'd0, len_m1};
  assign start     = stg.offset - {28'd0, len_m1};
  assign str_fail  = cfg.string_mode && (start != 32'd0) && (prev_byte != 8'd0);

  assign hit  = !done_r && off_ok && (&pos_ok) && !str_fail;
  assign emit = hit || (stg.last && !done_r);

  // The stage moves on when its word either makes no result or finds room.
  assign slot_free = !out_valid_r || out_ready;
  assign adv       = stg.valid && (slot_free || !emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        done_r <= stg.last ? 1'b0 : (done_r | hit);
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_data_r.match_found   <= hit;
      out_data_r.match_address <= hit ? cfg.search_base + start : 32'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/mbss_checker.sv
`default_nettype none

`include "masked_byte_signature_scan_assert.svh"

module mbss_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mbss_pkg::out_word_t out_data
);

  // A stalled result word holds.
  `MBSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data), "result word changed while stalled")

  // A region that ended without a match reports address zero.
  `MBSS_ASSERT_NOW(a_miss_zero, out_valid && !out_data.match_found,
                   out_data.match_address == 32'd0, "miss result with nonzero address")

  // Nothing is pending right after reset.
  `MBSS_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid, "result valid right after reset")

  // With no result waiting, an offered word is always taken.
  `MBSS_ASSERT_NOW(a_ready_no_result, in_valid && !out_valid, in_ready,
                   "input stalled with no result waiting")

endmodule

bind masked_byte_signature_scan mbss_checker u_mbss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### sim/masked_byte_signature_scan_tb.sv
`timescale 1ns / 1ps

module masked_byte_signature_scan_tb;

  localparam int     HOLD_CYCLES  = 200;
  localparam int     DRAIN_CYCLES = 6;
  localparam longint CYCLE_LIMIT  = 200000;

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  mbss_pkg::in_word_t          in_data   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  mbss_pkg::out_word_t         out_data;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [mbss_pkg::ADDR_W-1:0] paddr     = '0;
  logic [mbss_pkg::DATA_W-1:0] pwdata    = '0;
  logic [mbss_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  masked_byte_signature_scan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the configuration registers, at their reset values.
  logic [63:0]                pat_lo_q = '0;
  logic [63:0]                pat_hi_q = '0;
  logic [15:0]                wild_q   = '0;
  logic [mbss_pkg::LEN_W-1:0] len_q    = mbss_pkg::LEN_W'(1);
  logic                       str_q    = 1'b0;
  logic [31:0]                base_q   = '0;

  // Scanner state of the predictor.
  mbss_pkg::window_t hist        = '0;
  logic [31:0]       scan_offset = '0;
  bit                scan_done   = 1'b0;

  mbss_pkg::out_word_t pending_results[$];

  int     errors       = 0;
  int     bytes_sent   = 0;
  int     useful_bytes = 0;
  int     regions      = 0;
  int     hits         = 0;
  int     misses       = 0;
  bit     tx_idle_en   = 1'b1;
  bit     rx_idle_en   = 1'b1;
  bit     hold_req     = 1'b0;
  longint cycle_count  = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Pattern length as the scanner applies it.
  function automatic int unsigned active_length();
    if (len_q == 0) return 1;
    if (len_q > mbss_pkg::MAX_PATTERN) return mbss_pkg::MAX_PATTERN;
    return 32'(len_q);
  endfunction

  function automatic mbss_pkg::octet_t pattern_at(int unsigned j);
    logic [127:0] both;
    both = {pat_hi_q, pat_lo_q};
    return both[8*j +: 8];
  endfunction

  // Advance the scanner by one byte; returns 1 when the byte produces a result.
  function automatic bit scan_byte(input mbss_pkg::octet_t b, input bit last,
                                   output mbss_pkg::out_word_t res);
    int unsigned len;
    logic [31:0] cur;
    logic [31:0] start;
    bit          hit;
    bit          has_res;
    len     = active_length();
    cur     = scan_offset;
    hit     = 1'b0;
    start   = '0;
    has_res = 1'b0;
    res     = '0;
    hist    = {hist[mbss_pkg::WIN_DEPTH-2:0], b};
    if (!scan_done && cur >= len - 1) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (!wild_q[j] && pattern_at(j) != hist[len-1-j]) hit = 1'b0;
      end
      start = cur - (len - 1);
      // In string mode the byte ahead of the match must be zero, except at region start.
      if (hit && str_q && start != 0 && hist[len] != 8'h00) hit = 1'b0;
    end
    if (hit) begin
      res.match_found   = 1'b1;
      res.match_address = base_q + start;
      scan_done         = 1'b1;
      has_res           = 1'b1;
    end else if (last && !scan_done) begin
      has_res = 1'b1;
    end
    scan_offset = cur + 1;
    if (last) begin
      hist        = '0;
      scan_offset = '0;
      scan_done   = 1'b0;
    end
    return has_res;
  endfunction

  // Register write (setup, access), a read back of the same register, then a return to idle.
  task automatic write_reg(input logic [mbss_pkg::REG_IDX_W-1:0] idx,
                           input logic [63:0] value);
    logic [63:0] exp_val;
    exp_val = '0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      mbss_pkg::REG_PATTERN_LOW: begin
        pat_lo_q = value;
        exp_val  = value;
      end
      mbss_pkg::REG_PATTERN_HIGH: begin
        pat_hi_q = value;
        exp_val  = value;
      end
      mbss_pkg::REG_WILDCARD_MASK: begin
        wild_q  = value[15:0];
        exp_val = 64'(value[15:0]);
      end
      mbss_pkg::REG_PATTERN_LENGTH: begin
        len_q   = value[mbss_pkg::LEN_W-1:0];
        exp_val = 64'(value[mbss_pkg::LEN_W-1:0]);
      end
      mbss_pkg::REG_STRING_MODE: begin
        str_q   = value[0];
        exp_val = 64'(value[0]);
      end
      mbss_pkg::REG_SEARCH_BASE: begin
        base_q  = value[31:0];
        exp_val = 64'(value[31:0]);
      end
      default: ;
    endcase
    // Read the register back.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== exp_val) begin
      $display("%0t: register %0d read expected %h actual %h", $time, idx, exp_val, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] mask,
                            input logic [mbss_pkg::LEN_W-1:0] len,
                            input logic str, input logic [31:0] base);
    write_reg(mbss_pkg::REG_PATTERN_LOW, lo);
    write_reg(mbss_pkg::REG_PATTERN_HIGH, hi);
    write_reg(mbss_pkg::REG_WILDCARD_MASK, 64'(mask));
    write_reg(mbss_pkg::REG_PATTERN_LENGTH, 64'(len));
    write_reg(mbss_pkg::REG_STRING_MODE, 64'(str));
    write_reg(mbss_pkg::REG_SEARCH_BASE, 64'(base));
  endtask

  // Offer one word and wait for it to be taken; valid is left up when the task returns.
  task automatic send_byte(input mbss_pkg::octet_t b, input bit last);
    mbss_pkg::out_word_t res;
    int                  gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (!in_ready);
    if (!scan_done) useful_bytes++;
    bytes_sent++;
    if (last) regions++;
    if (scan_byte(b, last, res)) begin
      pending_results.push_back(res);
      if (res.match_found) hits++;
      else misses++;
    end
  endtask

  // Quiet point: input dropped, every result drained, pipeline settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Filler byte, biased toward pattern bytes and zeros so partial matches occur.
  function automatic mbss_pkg::octet_t noise_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return pattern_at($urandom_range(0, mbss_pkg::MAX_PATTERN - 1));
    if (pick < 6) return 8'h00;
    return mbss_pkg::octet_t'($urandom_range(0, 255));
  endfunction

  // One region: mostly a planted pattern among filler, otherwise plain filler.
  task automatic send_region();
    mbss_pkg::octet_t region_bytes[$];
    int unsigned      len;
    int unsigned      lead;
    int unsigned      n;
    len = active_length();
    if ($urandom_range(0, 9) < 7) begin
      lead = $urandom_range(0, 12);
      repeat (lead) region_bytes.push_back(noise_byte());
      if (str_q && lead > 0 && $urandom_range(0, 4) != 0) region_bytes[lead-1] = 8'h00;
      for (int j = 0; j < len; j++) begin
        region_bytes.push_back(wild_q[j] ? mbss_pkg::octet_t'($urandom_range(0, 255))
                                         : pattern_at(j));
      end
      repeat ($urandom_range(0, 3)) region_bytes.push_back(noise_byte());
      // Occasionally break the planted sequence.
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, region_bytes.size() - 1);
        region_bytes[n] = region_bytes[n] ^ mbss_pkg::octet_t'($urandom_range(1, 255));
      end
    end else begin
      n = $urandom_range(1, 24);
      repeat (n) region_bytes.push_back(noise_byte());
    end
    foreach (region_bytes[i]) send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  task automatic send_regions(input int budget);
    int target;
    target = useful_bytes + budget;
    while (useful_bytes < target) send_region();
  endtask

  // Reset values: one zero pattern byte, no wildcards, base zero.
  task automatic test_default_registers();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hA5, 1'b1);
  endtask

  // Full 16-byte pattern with wildcards, matching from region start and
  // ending on the final byte, with the base near the top of the address space.
  task automatic test_whole_pattern_at_start();
    wait_idle();
    set_config(64'hFF00_7E81_3C5A_A501, 64'h00FF_55AA_1234_8001, 16'h8421,
               mbss_pkg::LEN_W'(16), 1'b1, 32'hFFFF_FFF8);
    for (int j = 0; j < mbss_pkg::MAX_PATTERN; j++) begin
      send_byte(wild_q[j] ? ~pattern_at(j) : pattern_at(j), j == mbss_pkg::MAX_PATTERN - 1);
    end
  endtask

  // String mode rejects a match whose preceding byte is not zero.
  task automatic test_string_mode_guard();
    wait_idle();
    set_config(64'h4241, 64'h0, 16'h0000, mbss_pkg::LEN_W'(2), 1'b1, 32'h0000_1000);
    send_byte(8'h07, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
  endtask

  // Several register settings, the extremes among them, with random traffic.
  task automatic test_random_regions();
    for (int phase = 0; phase < 7; phase++) begin
      wait_idle();
      case (phase)
        0: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000,
                      mbss_pkg::LEN_W'(0), 1'b0, 32'h0);
        1: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF,
                      mbss_pkg::LEN_W'(16), 1'b1, 32'hFFFF_FFFF);
        2: set_config('1, '1, 16'($urandom & $urandom), mbss_pkg::LEN_W'(31), 1'b0,
                      32'hFFFF_FFFF);
        3: set_config(64'h0, 64'h0, 16'h0000, mbss_pkg::LEN_W'(1), 1'b1, 32'h0);
        default: set_config({$urandom, $urandom}, {$urandom, $urandom},
                            16'($urandom & $urandom),
                            mbss_pkg::LEN_W'($urandom_range(1, 16)),
                            1'($urandom), $urandom);
      endcase
      send_regions(150);
    end
  endtask

  // Receiver holds off while single-byte regions keep coming, so the block
  // fills and stalls its input.
  task automatic test_output_backpressure();
    wait_idle();
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF,
               mbss_pkg::LEN_W'(1), 1'b0, $urandom);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    repeat (60) send_byte(mbss_pkg::octet_t'($urandom_range(0, 255)), 1'b1);
    tx_idle_en = 1'b1;
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_unbroken_stream();
    wait_idle();
    set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom & $urandom),
               mbss_pkg::LEN_W'($urandom_range(1, 6)), 1'($urandom), $urandom);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_regions(150);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver: random stalls per word, plus one long hold-off on request.
  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = rx_idle_en ? $urandom_range(0, 5) : 0;
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    mbss_pkg::out_word_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result found=%0b address=%h",
                 $time, out_data.match_found, out_data.match_address);
        errors++;
      end else begin
        exp_word = pending_results.pop_front();
        if (out_data.match_found !== exp_word.match_found) begin
          $display("%0t: match_found expected %0b actual %0b",
                   $time, exp_word.match_found, out_data.match_found);
          errors++;
        end
        if (out_data.match_address !== exp_word.match_address) begin
          $display("%0t: match_address expected %h actual %h",
                   $time, exp_word.match_address, out_data.match_address);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("masked_byte_signature_scan regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_whole_pattern_at_start();
    test_string_mode_guard();
    test_random_regions();
    test_output_backpressure();
    test_unbroken_stream();
    wait_idle();
    $display("Scanned %0d bytes in %0d regions across twelve register settings,",
             bytes_sent, regions);
    $display("with %0d matches and %0d regions ending without one.", hits, misses);
    if (errors == 0) begin
      $display("masked_byte_signature_scan regression: pass");
    end else begin
      $display("masked_byte_signature_scan regression: fail");
    end
    $finish;
  end

endmodule

### masked_byte_signature_scan.f
+incdir+hdl
hdl/mbss_pkg.sv
hdl/mbss_cfg.sv
hdl/mbss_window.sv
hdl/mbss_match.sv
hdl/masked_byte_signature_scan.sv
hdl/mbss_checker.sv
sim/masked_byte_signature_scan_tb.sv
